// ----- rtl/core/tsmq_pkg.sv -----
package tsmq_pkg;

    // Queue capacity and the widths that follow from it.
    localparam int TSMQ_DEPTH = 1024;
    localparam int COUNT_W    = $clog2(TSMQ_DEPTH + 1);
    localparam int DATA_W     = 32;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_QUERY = 2'd0;
    localparam logic [1:0] FUNC_ENQ   = 2'd1;
    localparam logic [1:0] FUNC_DEQ   = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // Commands broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic  shift;
        logic  iterate;
        logic  push;
        data_t push_value;
    } chain_ctrl_t;

    // Signed maximum; on a tie both operands are the same bits.
    function automatic data_t max_of(data_t a, data_t b);
        return (a >= b) ? a : b;
    endfunction

endpackage

// ----- rtl/core/tsmq_if.sv -----
// Request channel: one operation per transaction.
interface tsmq_req_if import tsmq_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] func;
    data_t      value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

// Response channel: one result per transaction.
interface tsmq_rsp_if import tsmq_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t dequeued_value;
    data_t current_max;
    logic  is_empty;
    logic  error;

    modport source (output valid, output dequeued_value, output current_max,
                    output is_empty, output error, input ready);
    modport sink (input valid, input dequeued_value, input current_max,
                  input is_empty, input error, output ready);
endinterface

// ----- rtl/core/tsmq_cell.sv -----
module tsmq_cell import tsmq_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  logic  iterate,
    input  logic  push,
    input  data_t push_value,
    input  data_t nxt_value,
    input  data_t nxt_pm,
    output data_t value,
    output data_t pm
);

    data_t value_reg;
    data_t value_next;
    data_t pm_reg;
    data_t pm_next;

    // A dequeue moves every entry one cell toward the head. A push loads this
    // cell when it is the tail slot. During a transfer the running maximum
    // flows from the tail toward the head one cell per cycle.
    always_comb
    begin
        value_next = value_reg;
        pm_next    = pm_reg;
        priority if (shift)
        begin
            value_next = nxt_value;
            pm_next    = nxt_pm;
        end
        else if (push)
        begin
            value_next = push_value;
            pm_next    = push_value;
        end
        else if (iterate)
        begin
            pm_next = max_of(pm_reg, nxt_pm);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pm_reg    <= pm_next;
    end

    assign value = value_reg;
    assign pm    = pm_reg;

endmodule

// ----- rtl/core/tsmq_chain.sv -----
module tsmq_chain import tsmq_pkg::*;
(
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  count_t      total_cnt,
    input  count_t      in_cnt,
    output data_t       head_value,
    output data_t       head_pm,
    output data_t       second_pm
);

    data_t value_w [TSMQ_DEPTH];
    data_t pm_w    [TSMQ_DEPTH];

    genvar i;
    generate
        for (i = 0; i < TSMQ_DEPTH; i++)
        begin : g_cell
            logic  push_sel;
            logic  link;
            data_t nxt_value;
            data_t nxt_pm;

            // This cell is the tail slot when its index equals the fill count.
            assign push_sel = ctrl.push && (total_cnt == COUNT_W'(i));
            // The neighbor toward the tail still belongs to the moved stack.
            assign link = ctrl.iterate && (COUNT_W'(i + 1) < in_cnt);

            if (i == TSMQ_DEPTH - 1)
            begin : g_last
                assign nxt_value = '0;
                assign nxt_pm    = '0;
            end
            else
            begin : g_mid
                assign nxt_value = value_w[i+1];
                assign nxt_pm    = pm_w[i+1];
            end

            tsmq_cell u_cell (
                .clk        (clk),
                .shift      (ctrl.shift),
                .iterate    (link),
                .push       (push_sel),
                .push_value (ctrl.push_value),
                .nxt_value  (nxt_value),
                .nxt_pm     (nxt_pm),
                .value      (value_w[i]),
                .pm         (pm_w[i])
            );
        end
    endgenerate

    // The head of the queue always sits in the first cell.
    assign head_value = value_w[0];
    assign head_pm    = pm_w[0];
    assign second_pm  = pm_w[1];

endmodule

// ----- rtl/core/two_stack_max_queue.sv -----
// The request waits in a command register and the result is held in a response register.
// Throughput: one transaction per cycle for query, enqueue and dequeue from a filled
// output stack while responses are taken; a dequeue that finds the output stack empty
// first sweeps the input-stack entries through the cell chain to build their maxima.
// Reset (rst_n low, asynchronous) empties the queue; cell contents are not cleared.
module two_stack_max_queue import tsmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tsmq_req_if.sink  req,
    tsmq_rsp_if.source rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_XFER = 1'b1;

    logic        state_reg;
    logic        state_next;
    logic        cmd_valid_reg;
    logic        cmd_valid_next;
    logic [1:0]  cmd_func_reg;
    logic [1:0]  cmd_func_next;
    data_t       cmd_value_reg;
    data_t       cmd_value_next;
    count_t      in_cnt_reg;
    count_t      in_cnt_next;
    count_t      out_cnt_reg;
    count_t      out_cnt_next;
    count_t      xfer_cnt_reg;
    count_t      xfer_cnt_next;
    data_t       in_max_reg;
    data_t       in_max_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    data_t       res_dq_reg;
    data_t       res_dq_next;
    data_t       res_max_reg;
    data_t       res_max_next;
    logic        res_empty_reg;
    logic        res_empty_next;
    logic        res_err_reg;
    logic        res_err_next;

    chain_ctrl_t ctrl;
    count_t      total_cnt;
    data_t       head_value;
    data_t       head_pm;
    data_t       second_pm;
    data_t       cur_max;
    logic        need_xfer;
    logic        res_free;
    logic        exec;
    logic        out_keeps;

    // Cell chain holding the queue in order, head in the first cell.
    tsmq_chain u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .total_cnt  (total_cnt),
        .in_cnt     (in_cnt_reg),
        .head_value (head_value),
        .head_pm    (head_pm),
        .second_pm  (second_pm)
    );

    // Occupancy and handshake conditions.
    assign total_cnt = in_cnt_reg + out_cnt_reg;
    assign need_xfer = (cmd_func_reg == FUNC_DEQ) && (out_cnt_reg == '0)
                       && (in_cnt_reg != '0);
    assign res_free  = !res_valid_reg || rsp.ready;
    assign exec      = (state_reg == S_IDLE) && cmd_valid_reg && !need_xfer && res_free;
    assign out_keeps = out_cnt_reg > COUNT_W'(1);
    assign req.ready = !cmd_valid_reg || exec;

    // Maximum of the queue as it stands.
    always_comb
    begin
        priority if (in_cnt_reg != '0 && out_cnt_reg != '0)
            cur_max = max_of(in_max_reg, head_pm);
        else if (in_cnt_reg != '0)
            cur_max = in_max_reg;
        else if (out_cnt_reg != '0)
            cur_max = head_pm;
        else
            cur_max = '0;
    end

    // Controller: command register, operation execution and stack transfer.
    always_comb
    begin
        state_next      = state_reg;
        cmd_valid_next  = cmd_valid_reg;
        cmd_func_next   = cmd_func_reg;
        cmd_value_next  = cmd_value_reg;
        in_cnt_next     = in_cnt_reg;
        out_cnt_next    = out_cnt_reg;
        xfer_cnt_next   = xfer_cnt_reg;
        in_max_next     = in_max_reg;
        res_valid_next  = res_valid_reg;
        res_dq_next     = res_dq_reg;
        res_max_next    = res_max_reg;
        res_empty_next  = res_empty_reg;
        res_err_next    = res_err_reg;
        ctrl            = '0;
        ctrl.push_value = cmd_value_reg;

        if (rsp.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid_reg && need_xfer)
                begin
                    state_next    = S_XFER;
                    xfer_cnt_next = in_cnt_reg - COUNT_W'(1);
                end
                else if (exec)
                begin
                    cmd_valid_next = 1'b0;
                    res_valid_next = 1'b1;
                    res_dq_next    = '0;
                    res_err_next   = 1'b0;
                    res_max_next   = cur_max;
                    res_empty_next = (total_cnt == '0);
                    unique case (cmd_func_reg)
                        FUNC_ENQ:
                        begin
                            if (total_cnt == COUNT_W'(TSMQ_DEPTH))
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.push   = 1'b1;
                                in_cnt_next = in_cnt_reg + COUNT_W'(1);
                                if (in_cnt_reg != '0)
                                    in_max_next = max_of(in_max_reg, cmd_value_reg);
                                else
                                    in_max_next = cmd_value_reg;
                                if (out_cnt_reg != '0)
                                    res_max_next = max_of(head_pm, in_max_next);
                                else
                                    res_max_next = in_max_next;
                                res_empty_next = 1'b0;
                            end
                        end
                        FUNC_DEQ:
                        begin
                            if (total_cnt == '0)
                            begin
                                res_err_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.shift     = 1'b1;
                                out_cnt_next   = out_cnt_reg - COUNT_W'(1);
                                res_dq_next    = head_value;
                                res_empty_next = (in_cnt_reg == '0) && !out_keeps;
                                priority if (in_cnt_reg != '0 && out_keeps)
                                    res_max_next = max_of(in_max_reg, second_pm);
                                else if (in_cnt_reg != '0)
                                    res_max_next = in_max_reg;
                                else if (out_keeps)
                                    res_max_next = second_pm;
                                else
                                    res_max_next = '0;
                            end
                        end
                        default:
                        begin
                            res_max_next = cur_max;
                        end
                    endcase
                end
            end
            S_XFER:
            begin
                // Sweep the running maximum toward the head, then hand the
                // entries over to the output stack.
                if (xfer_cnt_reg != '0)
                begin
                    ctrl.iterate  = 1'b1;
                    xfer_cnt_next = xfer_cnt_reg - COUNT_W'(1);
                end
                else
                begin
                    out_cnt_next = in_cnt_reg;
                    in_cnt_next  = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capture a new transaction.
        if (req.valid && req.ready)
        begin
            cmd_valid_next = 1'b1;
            cmd_func_next  = req.func;
            cmd_value_next = req.value;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_valid_reg <= 1'b0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            xfer_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_valid_reg <= cmd_valid_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            xfer_cnt_reg  <= xfer_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_func_reg  <= cmd_func_next;
        cmd_value_reg <= cmd_value_next;
        in_max_reg    <= in_max_next;
        res_dq_reg    <= res_dq_next;
        res_max_reg   <= res_max_next;
        res_empty_reg <= res_empty_next;
        res_err_reg   <= res_err_next;
    end

    // Response channel.
    assign rsp.valid          = res_valid_reg;
    assign rsp.dequeued_value = res_dq_reg;
    assign rsp.current_max    = res_max_reg;
    assign rsp.is_empty       = res_empty_reg;
    assign rsp.error          = res_err_reg;

endmodule

// ----- rtl/core/tsmq_checker.sv -----
module tsmq_checker import tsmq_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  rsp_valid,
    input logic  rsp_ready,
    input data_t dequeued_value,
    input data_t current_max,
    input logic  is_empty,
    input logic  error
);

    // A stalled response holds its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(dequeued_value)
            && $stable(current_max) && $stable(is_empty) && $stable(error))
        else $error("response changed while stalled");

    // An empty queue reports a zero maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> current_max == '0)
        else $error("nonzero maximum on empty queue");

    // A refused operation removes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error |-> dequeued_value == '0)
        else $error("refused operation returned a value");

endmodule

bind two_stack_max_queue tsmq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .dequeued_value (rsp.dequeued_value),
    .current_max    (rsp.current_max),
    .is_empty       (rsp.is_empty),
    .error          (rsp.error)
);
